// ===== hdl/button_click_longpress_fsm_assert.svh =====
// Assertion macros for the button gesture decoder.
// Each macro expects clk and rst_n in scope.
`ifndef BUTTON_CLICK_LONGPRESS_FSM_ASSERT_SVH
`define BUTTON_CLICK_LONGPRESS_FSM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bclp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bclp_pkg;

  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int EVENT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [MS_W-1:0]       ms_t;
  typedef logic [EVENT_W-1:0]    event_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam event_t EV_NONE        = 3'd0;
  localparam event_t EV_CLICK       = 3'd1;
  localparam event_t EV_DOUBLE      = 3'd2;
  localparam event_t EV_LONG_START  = 3'd3;
  localparam event_t EV_LONG_DURING = 3'd4;
  localparam event_t EV_LONG_STOP   = 3'd5;

  localparam cfg_idx_t REG_ACTIVE_LOW   = 3'd0;
  localparam cfg_idx_t REG_DEBOUNCE_MS  = 3'd1;
  localparam cfg_idx_t REG_CLICK_MS     = 3'd2;
  localparam cfg_idx_t REG_PRESS_MS     = 3'd3;
  localparam cfg_idx_t REG_DOUBLE_EN    = 3'd4;

  localparam ms_t DEBOUNCE_MS_RST = 16'd50;
  localparam ms_t CLICK_MS_RST    = 16'd50;
  localparam ms_t PRESS_MS_RST    = 16'd500;

endpackage

`default_nettype wire

// ===== hdl/bclp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface btn_in_if import bclp_pkg::*; ;
  logic  valid;
  logic  ready;
  logic  raw_level;
  time_t now_ms;

  modport source (output valid, output raw_level, output now_ms, input ready);
  modport sink (input valid, input raw_level, input now_ms, output ready);
endinterface

interface btn_out_if import bclp_pkg::*; ;
  logic   valid;
  logic   ready;
  event_t event_code;
  logic   long_pressed;
  time_t  press_duration_ms;
  time_t  since_start_ms;

  modport source (output valid, output event_code, output long_pressed,
                  output press_duration_ms, output since_start_ms, input ready);
  modport sink (input valid, input event_code, input long_pressed,
                input press_duration_ms, input since_start_ms, output ready);
endinterface

interface btn_cfg_if import bclp_pkg::*; ;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/button_click_longpress_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Button gesture decoder: each input beat carries one sample of the button
// level and a millisecond time stamp, and produces exactly one result beat
// with an event code (none, click, double click, long-press start, during
// long press, long-press stop), the long-press flag, the last press duration
// and the time since the press started. The block takes one beat per clock
// cycle; a beat passes through an input register and then a result
// register, which presents its result until the output side takes it. The
// block holds at most two beats, and the input stalls only while both are
// held and the output is not taken. Configuration writes are always
// accepted and take effect at once; they should be made only while no beat
// is in flight.
module button_click_longpress_fsm import bclp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  btn_in_if.sink     in_if,
  btn_out_if.source  out_if,
  btn_cfg_if.sink    cfg_if
);

  `include "button_click_longpress_fsm_assert.svh"

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PRESSED  = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_SECOND   = 3'd3;
  localparam logic [2:0] ST_LONG     = 3'd4;

  logic  cfg_active_low_r;
  ms_t   cfg_debounce_r;
  ms_t   cfg_click_r;
  ms_t   cfg_press_r;
  logic  cfg_double_en_r;

  logic  s1_valid_r;
  logic  s1_level_r;
  time_t s1_now_r;

  logic [2:0] state_r, state_nxt;
  time_t      start_r, start_nxt;
  time_t      stop_r, stop_nxt;
  logic       long_r, long_nxt;
  event_t     ev_nxt;

  logic   out_valid_r;
  event_t out_event_r;
  logic   out_long_r;
  time_t  out_dur_r;
  time_t  out_since_r;

  logic  out_adv;
  logic  s1_fire;
  logic  active;
  time_t elapsed;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_low_r <= 1'b0;
      cfg_debounce_r   <= DEBOUNCE_MS_RST;
      cfg_click_r      <= CLICK_MS_RST;
      cfg_press_r      <= PRESS_MS_RST;
      cfg_double_en_r  <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_ACTIVE_LOW:  cfg_active_low_r <= cfg_if.data[0];
        REG_DEBOUNCE_MS: cfg_debounce_r   <= ms_t'(cfg_if.data);
        REG_CLICK_MS:    cfg_click_r      <= ms_t'(cfg_if.data);
        REG_PRESS_MS:    cfg_press_r      <= ms_t'(cfg_if.data);
        REG_DOUBLE_EN:   cfg_double_en_r  <= cfg_if.data[0];
        default: begin
        end
      endcase
    end
  end

  assign out_adv     = !out_valid_r || out_if.ready;
  assign s1_fire     = s1_valid_r && out_adv;
  assign in_if.ready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_level_r <= in_if.raw_level;
      s1_now_r   <= in_if.now_ms;
    end
  end

  assign active  = cfg_active_low_r ? !s1_level_r : s1_level_r;
  assign elapsed = s1_now_r - start_r;

  always_comb begin
    state_nxt = ST_IDLE;
    start_nxt = start_r;
    stop_nxt  = stop_r;
    long_nxt  = long_r;
    ev_nxt    = EV_NONE;
    case (state_r)
      ST_IDLE: begin
        if (active) begin
          start_nxt = s1_now_r;
          state_nxt = ST_PRESSED;
        end
      end
      ST_PRESSED: begin
        if (!active && elapsed < time_t'(cfg_debounce_r)) begin
          state_nxt = ST_IDLE;
        end else if (!active) begin
          stop_nxt  = s1_now_r;
          state_nxt = ST_RELEASED;
        end else if (elapsed > time_t'(cfg_press_r)) begin
          long_nxt  = 1'b1;
          ev_nxt    = EV_LONG_START;
          state_nxt = ST_LONG;
        end else begin
          state_nxt = ST_PRESSED;
        end
      end
      ST_RELEASED: begin
        if (!cfg_double_en_r || elapsed > time_t'(cfg_click_r)) begin
          ev_nxt    = EV_CLICK;
          state_nxt = ST_IDLE;
        end else if (active && elapsed > time_t'(cfg_debounce_r)) begin
          start_nxt = s1_now_r;
          state_nxt = ST_SECOND;
        end else begin
          state_nxt = ST_RELEASED;
        end
      end
      ST_SECOND: begin
        if (!active && elapsed > time_t'(cfg_debounce_r)) begin
          stop_nxt  = s1_now_r;
          ev_nxt    = EV_DOUBLE;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SECOND;
        end
      end
      ST_LONG: begin
        if (!active) begin
          long_nxt  = 1'b0;
          stop_nxt  = s1_now_r;
          ev_nxt    = EV_LONG_STOP;
          state_nxt = ST_IDLE;
        end else begin
          long_nxt  = 1'b1;
          ev_nxt    = EV_LONG_DURING;
          state_nxt = ST_LONG;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= '0;
      stop_r  <= '0;
      long_r  <= 1'b0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      stop_r  <= stop_nxt;
      long_r  <= long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_event_r <= ev_nxt;
      out_long_r  <= long_nxt;
      out_dur_r   <= stop_nxt - start_nxt;
      out_since_r <= s1_now_r - start_nxt;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.event_code        = out_event_r;
  assign out_if.long_pressed      = out_long_r;
  assign out_if.press_duration_ms = out_dur_r;
  assign out_if.since_start_ms    = out_since_r;

  `BCLP_ASSERT_SAME(a_long_flag_state, 1'b1, long_r == (state_r == ST_LONG),
    "Long-press flag disagrees with the long-press state.")
  `BCLP_ASSERT_SAME(a_state_legal, 1'b1, state_r <= ST_LONG,
    "State register holds an undefined code.")
  `BCLP_ASSERT_SAME(a_long_event_flag,
    out_valid_r && (out_event_r == EV_LONG_START || out_event_r == EV_LONG_DURING),
    out_long_r, "Long-press event reported without the long-press flag.")
  `BCLP_ASSERT_SAME(a_stop_event_flag, out_valid_r && out_event_r == EV_LONG_STOP,
    !out_long_r, "Long-press stop reported with the flag still set.")
  `BCLP_ASSERT_SAME(a_ready_only_on_stall, !in_if.ready,
    s1_valid_r && out_valid_r && !out_if.ready,
    "Input stalled while the result side could take a beat.")
  `BCLP_ASSERT_NEXT(a_state_holds_idle, !s1_fire, $stable(state_r),
    "State changed without a beat passing through.")

endmodule

`default_nettype wire
